[sv/swt4_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swt4_pkg
// Shared constants and types for the per-vertex top-four influence store.
// ----------------------------------------------------------------------------
package swt4_pkg;

   localparam int VERTEX_COUNT     = 4096;
   localparam int SLOTS_PER_VERTEX = 4;
   localparam int READ_SLOTS       = 4;

   localparam int ACTION_W = 2;
   localparam int VERTEX_W = 12;
   localparam int BONE_W   = 8;
   localparam int WEIGHT_W = 16;

   // only vertex indices reachable by the request field need storage
   localparam int MEM_DEPTH = (VERTEX_COUNT < (1 << VERTEX_W)) ? VERTEX_COUNT
                                                               : (1 << VERTEX_W);
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   // response buffer
   localparam int RSP_DEPTH = 3;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD   = 2'd0,
      ACT_READ  = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef logic [VERTEX_W-1:0] vertex_type;
   typedef logic [BONE_W-1:0]   bone_type;
   typedef logic [WEIGHT_W-1:0] weight_type;
   typedef logic [ADDR_W-1:0]   addr_type;

   typedef struct packed {
      weight_type [SLOTS_PER_VERTEX-1:0] weight;
      bone_type   [SLOTS_PER_VERTEX-1:0] bone;
   } entry_type;

   typedef struct packed {
      logic      en;
      addr_type  addr;
      entry_type data;
   } mem_wr_type;

   typedef struct packed {
      vertex_type                  vertex;
      weight_type [READ_SLOTS-1:0] weight;
      bone_type   [READ_SLOTS-1:0] bone;
   } result_type;

endpackage

[sv/swt4_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swt4 channel interfaces
// Valid/ready request and response channels of the influence store.
// ----------------------------------------------------------------------------
interface swt4_req_if;
   import swt4_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   vertex_type          vertex_index;
   bone_type            bone_index;
   weight_type          weight;

   modport source (output valid, output action, output vertex_index,
                   output bone_index, output weight, input ready);
   modport sink   (input valid, input action, input vertex_index,
                   input bone_index, input weight, output ready);
endinterface

interface swt4_rsp_if;
   import swt4_pkg::*;

   logic       valid;
   logic       ready;
   vertex_type out_vertex;
   weight_type weight_first;
   weight_type weight_second;
   weight_type weight_third;
   weight_type weight_fourth;
   bone_type   bone_first;
   bone_type   bone_second;
   bone_type   bone_third;
   bone_type   bone_fourth;

   modport source (output valid, output out_vertex,
                   output weight_first, output weight_second,
                   output weight_third, output weight_fourth,
                   output bone_first, output bone_second,
                   output bone_third, output bone_fourth, input ready);
   modport sink   (input valid, input out_vertex,
                   input weight_first, input weight_second,
                   input weight_third, input weight_fourth,
                   input bone_first, input bone_second,
                   input bone_third, input bone_fourth, output ready);
endinterface

[sv/swt4_entry_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swt4_entry_mem
// Single-port-write, single-port-read vertex entry memory, registered read.
// ----------------------------------------------------------------------------
module swt4_entry_mem (
   input  logic                 clock,
   input  swt4_pkg::mem_wr_type wr,
   input  logic                 rd_en,
   input  swt4_pkg::addr_type   rd_addr,
   output swt4_pkg::entry_type  rd_data
);
   import swt4_pkg::*;

   entry_type mem_ff [MEM_DEPTH];
   entry_type rd_data_ff;

   // read returns the old contents when the same entry is written
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/swt4_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swt4_update
// Modify step: sorted insertion of one influence, or clearing of an entry.
// ----------------------------------------------------------------------------
module swt4_update (
   input  logic [swt4_pkg::ACTION_W-1:0] action,
   input  swt4_pkg::weight_type          weight,
   input  swt4_pkg::bone_type            bone,
   input  swt4_pkg::entry_type           old_entry,
   output swt4_pkg::entry_type           new_entry,
   output logic                          write
);
   import swt4_pkg::*;

   logic [SLOTS_PER_VERTEX-1:0] gt;
   logic [SLOTS_PER_VERTEX-1:0] hit_above;
   entry_type                   shifted;
   entry_type                   inserted;

   always_comb begin
      for (int j = 0; j < SLOTS_PER_VERTEX; j++) begin
         gt[j] = weight > old_entry.weight[j];
      end
      // a slot below the first larger-than slot takes its upper neighbour
      hit_above[0] = 1'b0;
      for (int j = 1; j < SLOTS_PER_VERTEX; j++) begin
         hit_above[j] = hit_above[j-1] | gt[j-1];
      end
      shifted.weight[0] = '0;
      shifted.bone[0]   = '0;
      for (int j = 1; j < SLOTS_PER_VERTEX; j++) begin
         shifted.weight[j] = old_entry.weight[j-1];
         shifted.bone[j]   = old_entry.bone[j-1];
      end
      for (int j = 0; j < SLOTS_PER_VERTEX; j++) begin
         if (hit_above[j]) begin
            inserted.weight[j] = shifted.weight[j];
            inserted.bone[j]   = shifted.bone[j];
         end else if (gt[j]) begin
            inserted.weight[j] = weight;
            inserted.bone[j]   = bone;
         end else begin
            inserted.weight[j] = old_entry.weight[j];
            inserted.bone[j]   = old_entry.bone[j];
         end
      end
   end

   always_comb begin
      case (action)
         ACT_ADD: begin
            new_entry = inserted;
            write     = 1'b1;
         end
         ACT_CLEAR: begin
            new_entry = '0;
            write     = 1'b1;
         end
         default: begin
            new_entry = old_entry;
            write     = 1'b0;
         end
      endcase
   end

endmodule

[sv/swt4_rsp_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swt4_rsp_fifo
// Small response buffer that decouples the pipeline from the receiver.
// ----------------------------------------------------------------------------
module swt4_rsp_fifo (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  swt4_pkg::result_type                 push_data,
   output logic [swt4_pkg::RSP_CNT_W-1:0]       count,
   swt4_rsp_if.source                           rsp
);
   import swt4_pkg::*;

   result_type             buf_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;
   result_type             head;

   assign pop  = rsp.valid && rsp.ready;
   assign head = buf_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0
                                                              : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0
                                                              : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + RSP_CNT_W'(push) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign count             = count_ff;
   assign rsp.valid         = count_ff != '0;
   assign rsp.out_vertex    = head.vertex;
   assign rsp.weight_first  = head.weight[0];
   assign rsp.weight_second = head.weight[1];
   assign rsp.weight_third  = head.weight[2];
   assign rsp.weight_fourth = head.weight[3];
   assign rsp.bone_first    = head.bone[0];
   assign rsp.bone_second   = head.bone[1];
   assign rsp.bone_third    = head.bone[2];
   assign rsp.bone_fourth   = head.bone[3];

endmodule

[sv/skin_weight_top4_store_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skin_weight_top4_store_top
// Per-vertex store of the four largest bone influences, sorted descending.
// ----------------------------------------------------------------------------
// req carries add, read and clear requests for one vertex entry; rsp returns
// the four weights and bones of the vertex for every read request.
// An accepted request is looked up in the entry memory on the accept edge and
// modified and written back on the next edge, so one request per cycle is
// taken in steady state while the response buffer has room and no sweep runs;
// the single memory read port sets that rate, and a request that hits the
// entry written on its own accept edge takes the forwarded copy. A read result
// is pushed into the response buffer from the modify stage, and rsp.valid
// rises once the buffer holds it.
// After reset the memory is swept to zero, one entry per cycle, through all
// 4096 entries; req.ready stays low for the whole sweep.
// Up to three read results are held when the receiver stalls; once the buffer
// and the request in flight fill it, req.ready falls until rsp drains.
// ----------------------------------------------------------------------------
module skin_weight_top4_store_top (
   input  logic       clock,
   input  logic       reset,
   swt4_req_if.sink   req,
   swt4_rsp_if.source rsp
);
   import swt4_pkg::*;

   // clearing sweep
   logic     clr_busy_ff, clr_busy_in;
   addr_type clr_addr_ff, clr_addr_in;

   // modify stage
   logic                s1_valid_ff;
   logic [ACTION_W-1:0] s1_action_ff;
   vertex_type          s1_vertex_ff;
   bone_type            s1_bone_ff;
   weight_type          s1_weight_ff;
   logic                s1_ok_ff;

   // last write, for forwarding
   logic      fwd_valid_ff;
   addr_type  fwd_addr_ff;
   entry_type fwd_data_ff;

   logic                 req_fire;
   logic                 req_ok;
   logic                 s1_read;
   logic [RSP_CNT_W:0]   pending;
   logic [RSP_CNT_W-1:0] rsp_count;
   addr_type             s1_addr;
   entry_type            rd_entry;
   entry_type            cur_entry;
   entry_type            new_entry;
   logic                 upd_write;
   mem_wr_type           mem_wr;
   result_type           result;

   assign req_ok   = 32'(req.vertex_index) < 32'(VERTEX_COUNT);
   assign s1_read  = s1_valid_ff && (s1_action_ff == ACT_READ);
   assign pending  = {1'b0, rsp_count} + (RSP_CNT_W+1)'(s1_read);
   assign req.ready = !clr_busy_ff && (pending < (RSP_CNT_W+1)'(RSP_DEPTH));
   assign req_fire = req.valid && req.ready;
   assign s1_addr  = s1_vertex_ff[ADDR_W-1:0];

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(MEM_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= req_fire;
         fwd_valid_ff <= mem_wr.en;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_action_ff <= req.action;
         s1_vertex_ff <= req.vertex_index;
         s1_bone_ff   <= req.bone_index;
         s1_weight_ff <= req.weight;
         s1_ok_ff     <= req_ok;
      end
      fwd_addr_ff <= mem_wr.addr;
      fwd_data_ff <= mem_wr.data;
   end

   swt4_entry_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_en   (req_fire),
      .rd_addr (req.vertex_index[ADDR_W-1:0]),
      .rd_data (rd_entry)
   );

   // the entry written on the accept edge is not yet visible in the read data
   assign cur_entry = (fwd_valid_ff && (fwd_addr_ff == s1_addr)) ? fwd_data_ff
                                                                 : rd_entry;

   swt4_update u_update (
      .action    (s1_action_ff),
      .weight    (s1_weight_ff),
      .bone      (s1_bone_ff),
      .old_entry (cur_entry),
      .new_entry (new_entry),
      .write     (upd_write)
   );

   always_comb begin
      if (clr_busy_ff) begin
         mem_wr.en   = 1'b1;
         mem_wr.addr = clr_addr_ff;
         mem_wr.data = '0;
      end else begin
         mem_wr.en   = s1_valid_ff && s1_ok_ff && upd_write;
         mem_wr.addr = s1_addr;
         mem_wr.data = new_entry;
      end
   end

   assign result.vertex = s1_vertex_ff;

   for (genvar j = 0; j < READ_SLOTS; j++) begin : g_result
      if (j < SLOTS_PER_VERTEX) begin : g_slot
         assign result.weight[j] = s1_ok_ff ? cur_entry.weight[j] : '0;
         assign result.bone[j]   = s1_ok_ff ? cur_entry.bone[j]   : '0;
      end else begin : g_empty
         assign result.weight[j] = '0;
         assign result.bone[j]   = '0;
      end
   end

   swt4_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_read),
      .push_data (result),
      .count     (rsp_count),
      .rsp       (rsp)
   );

   // response buffer never overflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (rsp_count == RSP_CNT_W'(RSP_DEPTH)) |-> !s1_read)
      else $error("read result pushed into a full response buffer");

   // no request is taken while the sweep still owns the memory
   a_sweep_blocks: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_fire)
      else $error("request accepted during clearing sweep");

   // writes come only from the sweep or from a request in the modify stage
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_wr.en |-> (clr_busy_ff || (s1_valid_ff && s1_ok_ff)))
      else $error("memory write without a source");

   // the forwarding copy tracks the last write
   a_forward_tracks: assert property (@(posedge clock) disable iff (reset)
      mem_wr.en |=> (fwd_valid_ff && (fwd_addr_ff == $past(mem_wr.addr))))
      else $error("forwarding register lost the last write");

endmodule

[tb/skin_weight_top4_store_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skin_weight_top4_store_check
// Watches both channels of the influence store, keeps its own copy of the
// per-vertex top-four table, and checks every read response in order.
// ----------------------------------------------------------------------------
module skin_weight_top4_store_check (
   input  logic clock,
   input  logic reset,
   swt4_req_if  req,
   swt4_rsp_if  rsp,
   output int   fail_count,
   output int   pending_count
);
   import swt4_pkg::*;

   weight_type kept_weight [VERTEX_COUNT][SLOTS_PER_VERTEX];
   bone_type   kept_bone   [VERTEX_COUNT][SLOTS_PER_VERTEX];
   result_type expected_reads [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // new influence goes above the first strictly smaller weight
   task automatic rank_influence(int v, weight_type w, bone_type b);
      int slot = -1;
      for (int j = 0; j < SLOTS_PER_VERTEX; j++)
         if (slot < 0 && w > kept_weight[v][j]) slot = j;
      if (slot >= 0) begin
         for (int k = SLOTS_PER_VERTEX - 1; k > slot; k--) begin
            kept_weight[v][k] = kept_weight[v][k-1];
            kept_bone[v][k]   = kept_bone[v][k-1];
         end
         kept_weight[v][slot] = w;
         kept_bone[v][slot]   = b;
      end
   endtask

   task automatic clear_entry(int v);
      for (int j = 0; j < SLOTS_PER_VERTEX; j++) begin
         kept_weight[v][j] = '0;
         kept_bone[v][j]   = '0;
      end
   endtask

   function automatic result_type read_entry(vertex_type v);
      result_type r;
      r.vertex = v;
      for (int j = 0; j < READ_SLOTS; j++) begin
         r.weight[j] = '0;
         r.bone[j]   = '0;
         if (int'(v) < VERTEX_COUNT && j < SLOTS_PER_VERTEX) begin
            r.weight[j] = kept_weight[v][j];
            r.bone[j]   = kept_bone[v][j];
         end
      end
      return r;
   endfunction

   task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v !== got_v) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                  $time, name, exp_v, got_v);
      end
   endtask

   task automatic check_response();
      result_type got;
      result_type exp_r;
      got.vertex    = rsp.out_vertex;
      got.weight[0] = rsp.weight_first;
      got.weight[1] = rsp.weight_second;
      got.weight[2] = rsp.weight_third;
      got.weight[3] = rsp.weight_fourth;
      got.bone[0]   = rsp.bone_first;
      got.bone[1]   = rsp.bone_second;
      got.bone[2]   = rsp.bone_third;
      got.bone[3]   = rsp.bone_fourth;
      if (expected_reads.size() == 0) begin
         fail_count++;
         $display("%0t ns: unexpected response, expected none, actual vertex %0h",
                  $time, got.vertex);
      end else begin
         exp_r = expected_reads.pop_front();
         check_field("out_vertex", exp_r.vertex, got.vertex);
         for (int j = 0; j < READ_SLOTS; j++) begin
            check_field($sformatf("weight slot %0d", j), exp_r.weight[j], got.weight[j]);
            check_field($sformatf("bone slot %0d", j), exp_r.bone[j], got.bone[j]);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < VERTEX_COUNT; v++) clear_entry(v);
         expected_reads.delete();
      end else begin
         if (rsp.valid && rsp.ready) check_response();
         if (req.valid && req.ready) begin
            case (req.action)
               ACT_ADD: begin
                  if (int'(req.vertex_index) < VERTEX_COUNT)
                     rank_influence(int'(req.vertex_index), req.weight, req.bone_index);
               end
               ACT_CLEAR: begin
                  if (int'(req.vertex_index) < VERTEX_COUNT)
                     clear_entry(int'(req.vertex_index));
               end
               ACT_READ: expected_reads.push_back(read_entry(req.vertex_index));
               default: ;
            endcase
         end
      end
      pending_count = expected_reads.size();
   end

endmodule

[tb/skin_weight_top4_store_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skin_weight_top4_store_top_tb
// Drives add, read, clear and unused requests into the influence store with
// random gaps and response stalls; the checker beside the block predicts and
// compares every read response.
// ----------------------------------------------------------------------------
module skin_weight_top4_store_top_tb;
   import swt4_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS = 1000;
   localparam int IDLE_LIMIT      = 20000;
   localparam int DRAIN_CYCLES    = 16;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   idle_cycles;
   bit   send_no_gaps;
   bit   recv_no_stalls;

   swt4_req_if req_ch ();
   swt4_rsp_if rsp_ch ();

   skin_weight_top4_store_top uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   skin_weight_top4_store_check store_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // hold: park the sender until every read response has come back
   task automatic send_request(logic [ACTION_W-1:0] act, vertex_type v, bone_type b,
                               weight_type w, bit hold);
      int gap;
      gap = send_no_gaps ? 0 : $urandom_range(0, 13);
      if (hold) begin
         @(negedge clock) req_ch.valid <= 1'b0;
         wait (pending_count == 0);
      end
      repeat (gap) @(negedge clock) req_ch.valid <= 1'b0;
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.action       <= act;
      req_ch.vertex_index <= v;
      req_ch.bone_index   <= b;
      req_ch.weight       <= w;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // receiver side
   initial begin
      int stall;
      int taken;
      taken          = 0;
      recv_no_stalls = 1'b0;
      rsp_ch.ready   = 1'b0;
      forever begin
         stall = recv_no_stalls ? 0 : $urandom_range(0, 13);
         repeat (stall) @(negedge clock) rsp_ch.ready <= 1'b0;
         @(negedge clock) rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         taken++;
         if (taken % 40 == 0) recv_no_stalls = ($urandom_range(0, 3) == 0);
      end
   end

   // watchdog on cycles with no request or response moving
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int              hot_vertex [8];
      int              pick;
      logic [ACTION_W-1:0] act;
      vertex_type      v;
      weight_type      w;
      idle_cycles         = 0;
      send_no_gaps        = 1'b0;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.action       = ACT_ADD;
      req_ch.vertex_index = '0;
      req_ch.bone_index   = '0;
      req_ch.weight       = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: empty entry, zero weight, equal weights, eviction, edges
      send_request(ACT_READ,   12'h000, 8'h00, 16'h0000, 1'b0);
      send_request(ACT_ADD,    12'h000, 8'h00, 16'h0000, 1'b0);
      send_request(ACT_ADD,    12'h000, 8'hFF, 16'hFFFF, 1'b0);
      send_request(ACT_ADD,    12'h000, 8'h01, 16'h8000, 1'b0);
      send_request(ACT_ADD,    12'h000, 8'h02, 16'h8000, 1'b0);
      send_request(ACT_ADD,    12'h000, 8'h03, 16'h0001, 1'b0);
      send_request(ACT_READ,   12'h000, 8'h00, 16'h0000, 1'b0);
      send_request(ACT_ADD,    12'h000, 8'h04, 16'h4000, 1'b0);
      send_request(ACT_ADD,    12'h000, 8'h05, 16'h0001, 1'b0);
      send_request(ACT_ADD,    12'h000, 8'h06, 16'h4000, 1'b0);
      send_request(ACT_READ,   12'h000, 8'h00, 16'h0000, 1'b0);
      send_request(ACT_ADD,    12'hFFF, 8'hAA, 16'h5555, 1'b0);
      send_request(ACT_ADD,    12'hFFF, 8'h55, 16'hAAAA, 1'b0);
      send_request(ACT_READ,   12'hFFF, 8'h00, 16'h0000, 1'b0);
      send_request(ACT_UNUSED, 12'hFFF, 8'hFF, 16'hFFFF, 1'b0);
      send_request(ACT_READ,   12'hFFF, 8'h00, 16'h0000, 1'b0);
      send_request(ACT_CLEAR,  12'hFFF, 8'h00, 16'h0000, 1'b0);
      send_request(ACT_READ,   12'hFFF, 8'h00, 16'h0000, 1'b0);
      send_request(ACT_CLEAR,  12'h000, 8'h00, 16'h0000, 1'b0);
      send_request(ACT_READ,   12'h000, 8'h00, 16'h0000, 1'b0);
      send_request(ACT_ADD,    12'h5A5, 8'h33, 16'h0F0F, 1'b0);
      send_request(ACT_READ,   12'h5A5, 8'h00, 16'h0000, 1'b0);

      // a few vertices take most requests so entries fill and evict
      hot_vertex[0] = 0;
      hot_vertex[1] = VERTEX_COUNT - 1;
      for (int i = 2; i < 8; i++) hot_vertex[i] = $urandom_range(0, VERTEX_COUNT - 1);

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i % 50 == 0) send_no_gaps = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 60)      act = ACT_ADD;
         else if (pick < 88) act = ACT_READ;
         else if (pick < 94) act = ACT_CLEAR;
         else                act = ACT_UNUSED;
         if ($urandom_range(0, 99) < 85)
            v = vertex_type'(hot_vertex[$urandom_range(0, 7)]);
         else
            v = vertex_type'($urandom_range(0, VERTEX_COUNT - 1));
         pick = $urandom_range(0, 99);
         if (pick < 10)      w = '0;
         else if (pick < 15) w = '1;
         else if (pick < 40) w = {2'($urandom_range(0, 3)), 14'h0000};
         else                w = weight_type'($urandom_range(0, 65535));
         send_request(act, v, bone_type'($urandom_range(0, 255)), w, (i % 250 == 0));
      end

      @(negedge clock) req_ch.valid <= 1'b0;
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

[skin_weight_top4_store_top.f]
sv/swt4_pkg.sv
sv/swt4_if.sv
sv/swt4_entry_mem.sv
sv/swt4_update.sv
sv/swt4_rsp_fifo.sv
sv/skin_weight_top4_store_top.sv
tb/skin_weight_top4_store_check.sv
tb/skin_weight_top4_store_top_tb.sv
